[rtl/lcg_pkg.sv]
// shared constants, types and the cosine table builder of the linear chirp generator
// no dependencies; used by every module of the block
package lcg_pkg;

  // sizes of the datapath
  localparam int PHASE_BITS  = 32;
  localparam int TABLE_DEPTH = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 24;

  localparam int QBITS       = PHASE_BITS - 2;
  localparam int TABLE_BITS  = $clog2(TABLE_DEPTH);
  localparam int MAG_BITS    = SAMPLE_BITS - 1;
  localparam int AMP_BITS    = 16;
  localparam int PROD_BITS   = MAG_BITS + AMP_BITS;
  localparam int CFG_BITS    = 32;
  localparam int CFG_ADDR_BITS = 3;
  localparam int IN_BYTES_BITS  = 8;
  localparam int OUT_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;

  // pi in Q30 for the table series
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // register indexes of the configuration port
  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_SAMPLE_COUNT = 3'd0,
    REG_START_FREQ   = 3'd1,
    REG_SWEEP_RATE   = 3'd2,
    REG_START_PHASE  = 3'd3,
    REG_AMPLITUDE    = 3'd4
  } cfg_reg_t;

  // register reset values
  localparam logic [COUNT_BITS-1:0] SAMPLE_COUNT_RST = COUNT_BITS'(1024);
  localparam logic [AMP_BITS-1:0]   AMPLITUDE_RST    = AMP_BITS'(32768);

  // configuration register set
  typedef struct packed {
    logic [COUNT_BITS-1:0]      sample_count;
    logic [CFG_BITS-1:0]        start_freq;
    logic signed [CFG_BITS-1:0] sweep_rate;
    logic [CFG_BITS-1:0]        start_phase;
    logic [AMP_BITS-1:0]        amplitude;
  } cfg_t;

  // table address and sign for one sample
  typedef struct packed {
    logic [TABLE_BITS-1:0] addr;
    logic                  neg;
    logic                  last;
  } lookup_t;

  // cosine magnitude read from the table
  typedef struct packed {
    logic [MAG_BITS-1:0] mag;
    logic                neg;
    logic                last;
  } cos_word_t;

  typedef logic [MAG_BITS-1:0] cos_table_t [TABLE_DEPTH];

  // quarter-wave cosine, integer taylor series in q30, worked out at elaboration
  function automatic cos_table_t build_cos_table();
    cos_table_t         tbl;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    logic [63:0]        scale;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      scale = 64'd1 << (SAMPLE_BITS - 1);
      x     = (64'(2 * k + 1) * PI_Q30) / 64'(4 * TABLE_DEPTH);
      x2    = (x * x) >> 30;
      term  = 64'd1 << 30;
      sum   = signed'(term);
      for (int n = 0; n < 12; n++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2 * n + 1) * (2 * n + 2));
        if (n % 2 == 1) sum = sum + signed'(term);
        else            sum = sum - signed'(term);
      end
      if (sum < 0) sum = 64'sd0;
      v = ((64'(sum) * scale) + (64'd1 << 29)) >> 30;
      if (v > scale - 64'd1) v = scale - 64'd1;
      tbl[k] = MAG_BITS'(v);
    end
    return tbl;
  endfunction

endpackage

[rtl/lcg_phase.sv]
// second-order phase accumulator, burst index and quadrant decode
// depends on lcg_pkg
module lcg_phase (
  input  logic             clk,
  input  logic             rst_n,
  input  lcg_pkg::cfg_t    cfg,
  input  logic             accept,
  input  logic             restart,
  output lcg_pkg::lookup_t lookup
);
  import lcg_pkg::*;

  logic [PHASE_BITS-1:0] phase_acc_r, phase_acc_nxt;
  logic [PHASE_BITS-1:0] phase_step_r, phase_step_nxt;
  logic [COUNT_BITS-1:0] index_r, index_nxt;

  logic [PHASE_BITS-1:0] start_phase_p;
  logic [PHASE_BITS-1:0] step_init;
  logic [PHASE_BITS-1:0] sweep_twice;
  logic [PHASE_BITS-1:0] cur_phase;
  logic [PHASE_BITS-1:0] cur_step;
  logic [COUNT_BITS-1:0] cur_index;
  logic [COUNT_BITS-1:0] final_index;
  logic                  is_last;
  logic [1:0]            quad;
  logic [TABLE_BITS-1:0] idx;
  logic signed [63:0]    sweep_ext;

  // burst start values, reduced to the phase width
  always_comb begin
    sweep_ext     = 64'(cfg.sweep_rate);
    start_phase_p = PHASE_BITS'({32'd0, cfg.start_phase});
    step_init     = PHASE_BITS'({32'd0, cfg.start_freq} + 64'(sweep_ext));
    sweep_twice   = PHASE_BITS'(64'(sweep_ext) << 1);
  end

  // values seen by this sample, a restart loads the burst first
  always_comb begin
    cur_phase   = restart ? start_phase_p : phase_acc_r;
    cur_step    = restart ? step_init : phase_step_r;
    cur_index   = restart ? '0 : index_r;
    final_index = (cfg.sample_count == '0) ? '0 : cfg.sample_count - COUNT_BITS'(1);
    is_last     = cur_index >= final_index;
  end

  // accumulator update, reload after the final sample
  always_comb begin
    if (is_last) begin
      phase_acc_nxt  = start_phase_p;
      phase_step_nxt = step_init;
      index_nxt      = '0;
    end else begin
      phase_acc_nxt  = cur_phase + cur_step;
      phase_step_nxt = cur_step + sweep_twice;
      index_nxt      = cur_index + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r  <= '0;
      phase_step_r <= '0;
      index_r      <= '0;
    end else if (accept) begin
      phase_acc_r  <= phase_acc_nxt;
      phase_step_r <= phase_step_nxt;
      index_r      <= index_nxt;
    end
  end

  // quadrant decode: odd quadrants mirror the table, middle two negate
  always_comb begin
    quad        = cur_phase[PHASE_BITS-1 -: 2];
    idx         = cur_phase[QBITS-1 -: TABLE_BITS];
    lookup.addr = quad[0] ? ~idx : idx;
    lookup.neg  = quad[1] ^ quad[0];
    lookup.last = is_last;
  end

endmodule

[rtl/lcg_cos_rom.sv]
// quarter-wave cosine rom with registered read
// depends on lcg_pkg for the table contents and word types
module lcg_cos_rom (
  input  logic               clk,
  input  logic               en,
  input  lcg_pkg::lookup_t   lookup,
  output lcg_pkg::cos_word_t word
);
  import lcg_pkg::*;

  localparam cos_table_t COS_TABLE = build_cos_table();

  logic [MAG_BITS-1:0] mag_r;
  logic                neg_r;
  logic                last_r;

  // table read, held while the stage stalls
  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= COS_TABLE[lookup.addr];
      neg_r  <= lookup.neg;
      last_r <= lookup.last;
    end
  end

  assign word.mag  = mag_r;
  assign word.neg  = neg_r;
  assign word.last = last_r;

endmodule

[rtl/lcg_scale.sv]
// amplitude multiply, round half up and saturate to the sample width
// depends on lcg_pkg
module lcg_scale (
  input  logic                          clk,
  input  logic                          en_mul,
  input  logic                          en_out,
  input  lcg_pkg::cos_word_t            word,
  input  logic [lcg_pkg::AMP_BITS-1:0]  amplitude,
  output logic [lcg_pkg::SAMPLE_BITS-1:0] sample,
  output logic                          last
);
  import lcg_pkg::*;

  localparam int SW = PROD_BITS + 2;
  localparam logic signed [SW-1:0] ROUND  = SW'(1) <<< (SAMPLE_BITS - 2);
  localparam logic signed [SW-1:0] SAT_HI = (SW'(1) <<< (SAMPLE_BITS - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

  logic [PROD_BITS-1:0]         mag_prod;
  logic signed [PROD_BITS:0]    prod_nxt, prod_r;
  logic                         last_mul_r;
  logic signed [SW-1:0]         rounded;
  logic signed [SW-1:0]         shifted;
  logic [SAMPLE_BITS-1:0]       sample_nxt, sample_r;
  logic                         last_r;

  // signed product of cosine and gain
  always_comb begin
    mag_prod = PROD_BITS'(word.mag) * PROD_BITS'(amplitude);
    prod_nxt = word.neg ? -signed'({1'b0, mag_prod}) : signed'({1'b0, mag_prod});
  end

  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod_r     <= prod_nxt;
      last_mul_r <= word.last;
    end
  end

  // floor of (p + half) over the scale, then clamp
  always_comb begin
    rounded = SW'(prod_r) + ROUND;
    shifted = rounded >>> (SAMPLE_BITS - 1);
    if (shifted > SAT_HI)      sample_nxt = SAT_HI[SAMPLE_BITS-1:0];
    else if (shifted < SAT_LO) sample_nxt = SAT_LO[SAMPLE_BITS-1:0];
    else                       sample_nxt = shifted[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      sample_r <= sample_nxt;
      last_r   <= last_mul_r;
    end
  end

  assign sample = sample_r;
  assign last   = last_r;

endmodule

[rtl/linear_chirp_generator.sv]
// linear fm chirp generator: one sample word per accepted tick word
// an accepted tick's sample reaches the output through these registered stages
// (table read stage, multiply stage, output register)
// throughput: one word per cycle; each stage stalls only when the one after it is full
// reset (synchronous, rst_n low) clears the registers to their defaults, the burst
// to index zero and empties the pipeline; the cosine rom needs no clearing
module linear_chirp_generator (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: bit 0 restart, rest zero
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lcg_pkg::IN_BYTES_BITS-1:0]  in_tdata,
  // out_tdata: sample (signed), then zero padding
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lcg_pkg::OUT_DATA_BITS-1:0]  out_tdata,
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic [lcg_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [lcg_pkg::CFG_BITS-1:0]       cfg_wdata
);
  import lcg_pkg::*;

  cfg_t      cfg_r;
  lookup_t   lookup;
  cos_word_t word;
  logic      v1_r, v2_r, v3_r;
  logic      accept, en2, en3;
  logic [SAMPLE_BITS-1:0] sample;
  logic      last;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_count <= SAMPLE_COUNT_RST;
      cfg_r.start_freq   <= '0;
      cfg_r.sweep_rate   <= '0;
      cfg_r.start_phase  <= '0;
      cfg_r.amplitude    <= AMPLITUDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SAMPLE_COUNT: cfg_r.sample_count <= COUNT_BITS'(cfg_wdata[23:0]);
        REG_START_FREQ:   cfg_r.start_freq   <= cfg_wdata;
        REG_SWEEP_RATE:   cfg_r.sweep_rate   <= signed'(cfg_wdata);
        REG_START_PHASE:  cfg_r.start_phase  <= cfg_wdata;
        REG_AMPLITUDE:    cfg_r.amplitude    <= cfg_wdata[AMP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // stage enables, each stage moves when the next is empty or moving
  always_comb begin
    en3       = v2_r && (!v3_r || out_tready);
    en2       = v1_r && (!v2_r || en3);
    in_tready = !v1_r || en2;
    accept    = in_tvalid && in_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (accept)   v1_r <= 1'b1;
      else if (en2) v1_r <= 1'b0;
      if (en2)      v2_r <= 1'b1;
      else if (en3) v2_r <= 1'b0;
      if (en3)             v3_r <= 1'b1;
      else if (out_tready) v3_r <= 1'b0;
    end
  end

  lcg_phase u_phase (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .accept  (accept),
    .restart (in_tdata[0]),
    .lookup  (lookup)
  );

  lcg_cos_rom u_rom (
    .clk    (clk),
    .en     (accept),
    .lookup (lookup),
    .word   (word)
  );

  lcg_scale u_scale (
    .clk       (clk),
    .en_mul    (en2),
    .en_out    (en3),
    .word      (word),
    .amplitude (cfg_r.amplitude),
    .sample    (sample),
    .last      (last)
  );

  assign out_tvalid = v3_r;
  assign out_tdata  = OUT_DATA_BITS'(sample);
  assign out_tlast  = last;

  // full pipeline behind a stalled output takes no new word
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && !out_tready) |-> !in_tready)
    else $error("input accepted while the pipeline is full and stalled");

  // an accepted word occupies the first stage on the next cycle
  a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> v1_r)
    else $error("accepted word lost from the table stage");

  // output only becomes valid from a filled multiply stage
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(v2_r))
    else $error("output valid without a word in the multiply stage");

  // a moving multiply stage never overwrites an unmoved output
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (en3 && v3_r) |-> out_tready)
    else $error("output register overwritten before it was taken");

endmodule
